>>> hdl/aasp_pkg.sv
// shared types, constants and register codes of the activity, step and posture detector
package aasp_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int TICK_W      = 32;
  localparam int COUNT_W     = 8;
  localparam int CODE_W      = 4;
  localparam int FUNC_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int LIMIT_W     = 12;
  localparam int GAP_W       = 16;

  // spans are reduced in groups of this many window entries
  localparam int GROUP_N = 8;

  localparam int WINDOW_LEN_DEF     = 10;
  localparam int STEPS_TO_LATCH_DEF = 3;
  localparam int IDLE_SECONDS_DEF   = 3;

  localparam logic [FUNC_W-1:0] FUNC_PUSH        = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_PUSH_DETECT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_DETECT      = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LIMIT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW_LIMIT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_DEV    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WALK_DEV   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_REARM      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_REST       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_WALK_GAP   = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_RUN_GAP    = 3'd7;

  localparam logic [LIMIT_W-1:0] HIGH_LIMIT_RST = 12'd300;
  localparam logic [LIMIT_W-1:0] LOW_LIMIT_RST  = 12'd90;
  localparam logic [LIMIT_W-1:0] RUN_DEV_RST    = 12'd200;
  localparam logic [LIMIT_W-1:0] WALK_DEV_RST   = 12'd30;
  localparam logic [LIMIT_W-1:0] REARM_RST      = 12'd3;
  localparam logic [LIMIT_W-1:0] REST_RST       = 12'd127;
  localparam logic [GAP_W-1:0]   WALK_GAP_RST   = 16'd80;
  localparam logic [GAP_W-1:0]   RUN_GAP_RST    = 16'd60;

  localparam logic [CODE_W-1:0] POS_RUN       = 4'd0;
  localparam logic [CODE_W-1:0] POS_FACE_DOWN = 4'd1;
  localparam logic [CODE_W-1:0] POS_FACE_UP   = 4'd2;
  localparam logic [CODE_W-1:0] POS_LEFT      = 4'd3;
  localparam logic [CODE_W-1:0] POS_RIGHT     = 4'd4;
  localparam logic [CODE_W-1:0] POS_HEAD_UP   = 4'd5;
  localparam logic [CODE_W-1:0] POS_HEAD_DOWN = 4'd6;
  localparam logic [CODE_W-1:0] POS_LOW       = 4'd7;
  localparam logic [CODE_W-1:0] POS_HIGH      = 4'd8;
  localparam logic [CODE_W-1:0] POS_WALK      = 4'd9;

  typedef struct packed {
    logic [LIMIT_W-1:0] high_limit;
    logic [LIMIT_W-1:0] low_limit;
    logic [LIMIT_W-1:0] run_dev;
    logic [LIMIT_W-1:0] walk_dev;
    logic [LIMIT_W-1:0] rearm;
    logic [LIMIT_W-1:0] rest;
    logic [GAP_W-1:0]   walk_gap;
    logic [GAP_W-1:0]   run_gap;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] span;
    logic [SAMPLE_BITS-1:0] mean_mag;
    logic                   mean_neg;
    logic [SAMPLE_BITS-1:0] newest;
  } lane_res_t;

  typedef struct packed {
    logic [CODE_W-1:0]  posture;
    logic               walking;
    logic               running;
    logic [COUNT_W-1:0] walk_steps;
    logic [COUNT_W-1:0] run_steps;
  } stat_t;

endpackage

>>> hdl/aasp_if.sv
// input and result channels of the detector, valid/ready handshake
interface aasp_in_if;
  logic                                   valid;
  logic                                   ready;
  logic [aasp_pkg::FUNC_W-1:0]            func;
  logic signed [aasp_pkg::SAMPLE_BITS-1:0] accel_x;
  logic signed [aasp_pkg::SAMPLE_BITS-1:0] accel_y;
  logic signed [aasp_pkg::SAMPLE_BITS-1:0] accel_z;
  logic [aasp_pkg::TICK_W-1:0]            sample_tick;
  logic [aasp_pkg::TICK_W-1:0]            second_tick;

  modport source (
    output valid, func, accel_x, accel_y, accel_z, sample_tick, second_tick,
    input  ready
  );
  modport sink (
    input  valid, func, accel_x, accel_y, accel_z, sample_tick, second_tick,
    output ready
  );
endinterface

interface aasp_out_if;
  logic                         valid;
  logic                         ready;
  logic [aasp_pkg::CODE_W-1:0]  posture_code;
  logic                         walking;
  logic                         running;
  logic [aasp_pkg::COUNT_W-1:0] walk_steps;
  logic [aasp_pkg::COUNT_W-1:0] run_steps;

  modport source (
    output valid, posture_code, walking, running, walk_steps, run_steps,
    input  ready
  );
  modport sink (
    input  valid, posture_code, walking, running, walk_steps, run_steps,
    output ready
  );
endinterface

>>> hdl/accel_activity_step_posture_detector.sv
// Activity, step and posture detector for three-axis accelerometer samples. Each input
// transfer pushes a sample into a per-axis window (func 0), pushes and then runs a detect
// pass (func 1), or only detects (func 2); every transfer yields one result transfer with
// the posture code, the walking/running flags and the saturating step counts. One item is
// taken at a time: a push-only item goes from accept to result load, and a detect item
// goes through accept, registered group min/max and mean multiply in each axis lane, detect
// and merge, and result load, which waits while the sink has not taken the last result.
// Window, cfg, control and detector state clear asynchronously on reset; no clearing pass.
// Configuration registers may be written whenever the block is idle.
module accel_activity_step_posture_detector #(
  parameter int WINDOW_LEN     = aasp_pkg::WINDOW_LEN_DEF,
  parameter int STEPS_TO_LATCH = aasp_pkg::STEPS_TO_LATCH_DEF,
  parameter int IDLE_SECONDS   = aasp_pkg::IDLE_SECONDS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [aasp_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [aasp_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  aasp_in_if.sink                         in_i,
  aasp_out_if.source                      out_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_REDUCE = 2'd1;
  localparam logic [1:0] ST_DETECT = 2'd2;
  localparam logic [1:0] ST_OUT    = 2'd3;

  localparam int LW = aasp_pkg::LIMIT_W;

  logic [1:0]                  state_q, state_d;
  logic                        in_xfer, is_push, is_detect, out_load;
  logic [aasp_pkg::TICK_W-1:0] tick_q, sec_q;
  aasp_pkg::cfg_t              cfg_q;
  aasp_pkg::lane_res_t         res_x, res_y, res_z;
  aasp_pkg::stat_t             stat;
  logic                        out_valid_q;
  aasp_pkg::stat_t             out_q;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign is_push    = (in_i.func == aasp_pkg::FUNC_PUSH)
                   || (in_i.func == aasp_pkg::FUNC_PUSH_DETECT);
  assign is_detect  = (in_i.func == aasp_pkg::FUNC_PUSH_DETECT)
                   || (in_i.func == aasp_pkg::FUNC_DETECT);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.high_limit <= aasp_pkg::HIGH_LIMIT_RST;
      cfg_q.low_limit  <= aasp_pkg::LOW_LIMIT_RST;
      cfg_q.run_dev    <= aasp_pkg::RUN_DEV_RST;
      cfg_q.walk_dev   <= aasp_pkg::WALK_DEV_RST;
      cfg_q.rearm      <= aasp_pkg::REARM_RST;
      cfg_q.rest       <= aasp_pkg::REST_RST;
      cfg_q.walk_gap   <= aasp_pkg::WALK_GAP_RST;
      cfg_q.run_gap    <= aasp_pkg::RUN_GAP_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        aasp_pkg::CFG_HIGH_LIMIT: cfg_q.high_limit <= cfg_wdata_i[LW-1:0];
        aasp_pkg::CFG_LOW_LIMIT:  cfg_q.low_limit  <= cfg_wdata_i[LW-1:0];
        aasp_pkg::CFG_RUN_DEV:    cfg_q.run_dev    <= cfg_wdata_i[LW-1:0];
        aasp_pkg::CFG_WALK_DEV:   cfg_q.walk_dev   <= cfg_wdata_i[LW-1:0];
        aasp_pkg::CFG_REARM:      cfg_q.rearm      <= cfg_wdata_i[LW-1:0];
        aasp_pkg::CFG_REST:       cfg_q.rest       <= cfg_wdata_i[LW-1:0];
        aasp_pkg::CFG_WALK_GAP:   cfg_q.walk_gap   <= cfg_wdata_i;
        aasp_pkg::CFG_RUN_GAP:    cfg_q.run_gap    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_xfer) state_d = is_detect ? ST_REDUCE : ST_OUT;
      end
      ST_REDUCE: state_d = ST_DETECT;
      ST_DETECT: state_d = ST_OUT;
      ST_OUT: begin
        if (out_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      tick_q <= in_i.sample_tick;
      sec_q  <= in_i.second_tick;
    end
    if (out_load) out_q <= stat;
  end

  aasp_lane #(.WINDOW_LEN(WINDOW_LEN)) u_lane_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_xfer && is_push),
    .sample_i (in_i.accel_x),
    .reduce_i (state_q == ST_REDUCE),
    .res_o    (res_x)
  );

  aasp_lane #(.WINDOW_LEN(WINDOW_LEN)) u_lane_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_xfer && is_push),
    .sample_i (in_i.accel_y),
    .reduce_i (state_q == ST_REDUCE),
    .res_o    (res_y)
  );

  aasp_lane #(.WINDOW_LEN(WINDOW_LEN)) u_lane_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (in_xfer && is_push),
    .sample_i (in_i.accel_z),
    .reduce_i (state_q == ST_REDUCE),
    .res_o    (res_z)
  );

  aasp_detect #(
    .STEPS_TO_LATCH (STEPS_TO_LATCH),
    .IDLE_SECONDS   (IDLE_SECONDS)
  ) u_detect (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .detect_i (state_q == ST_DETECT),
    .cfg_i    (cfg_q),
    .tick_i   (tick_q),
    .sec_i    (sec_q),
    .res_x_i  (res_x),
    .res_y_i  (res_y),
    .res_z_i  (res_z),
    .stat_o   (stat)
  );

  assign out_o.valid        = out_valid_q;
  assign out_o.posture_code = out_q.posture;
  assign out_o.walking      = out_q.walking;
  assign out_o.running      = out_q.running;
  assign out_o.walk_steps   = out_q.walk_steps;
  assign out_o.run_steps    = out_q.run_steps;

`ifndef ASSERT_OFF
  reduce_then_detect_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_REDUCE) |=> (state_q == ST_DETECT))
    else $error("reduce stage not followed by detect");

  detect_item_path_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && is_detect) |=> (state_q == ST_REDUCE))
    else $error("detect item skipped the reduce stage");

  push_item_path_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !is_detect) |=> (state_q == ST_OUT))
    else $error("push-only item did not go straight to result load");

  load_sets_valid_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_valid_q && (out_q == $past(stat))))
    else $error("result register not loaded from detector state");
`endif

endmodule

>>> hdl/aasp_lane.sv
// one axis lane: sample window, running sum, grouped min/max and truncated mean
module aasp_lane #(
  parameter int WINDOW_LEN = aasp_pkg::WINDOW_LEN_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             push_i,
  input  logic [aasp_pkg::SAMPLE_BITS-1:0] sample_i,
  input  logic                             reduce_i,
  output aasp_pkg::lane_res_t              res_o
);

  localparam int SB     = aasp_pkg::SAMPLE_BITS;
  localparam int IDX_W  = $clog2(WINDOW_LEN);
  localparam int SUM_W  = SB + IDX_W;
  localparam int MEAN_K = SUM_W + IDX_W;
  localparam int MEAN_M = ((1 << MEAN_K) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam int PROD_W = 2 * SUM_W + 1;
  localparam int NGRP   = (WINDOW_LEN + aasp_pkg::GROUP_N - 1) / aasp_pkg::GROUP_N;

  logic [SB-1:0]        win_q [WINDOW_LEN];
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [SUM_W-1:0]     sum_abs;
  logic [PROD_W-1:0]    prod;
  logic [SB-1:0]        mean_mag_q;
  logic                 mean_neg_q;
  logic signed [SB-1:0] grp_hi_d [NGRP];
  logic signed [SB-1:0] grp_lo_d [NGRP];
  logic signed [SB-1:0] grp_hi_q [NGRP];
  logic signed [SB-1:0] grp_lo_q [NGRP];
  logic signed [SB-1:0] hi, lo;
  logic [SB:0]          span_full;

  assign sum_d = sum_q + {{IDX_W{sample_i[SB-1]}}, sample_i}
                       - {{IDX_W{win_q[0][SB-1]}}, win_q[0]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW_LEN; i++) win_q[i] <= '0;
      sum_q <= '0;
    end else if (push_i) begin
      for (int i = 0; i < WINDOW_LEN - 1; i++) win_q[i] <= win_q[i+1];
      win_q[WINDOW_LEN-1] <= sample_i;
      sum_q <= sum_d;
    end
  end

  // each group scans at most GROUP_N entries
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_hi_d[g] = $signed(win_q[g*aasp_pkg::GROUP_N]);
      grp_lo_d[g] = $signed(win_q[g*aasp_pkg::GROUP_N]);
      for (int j = 1; j < aasp_pkg::GROUP_N; j++) begin
        if (g*aasp_pkg::GROUP_N + j < WINDOW_LEN) begin
          if ($signed(win_q[g*aasp_pkg::GROUP_N + j]) > grp_hi_d[g]) begin
            grp_hi_d[g] = $signed(win_q[g*aasp_pkg::GROUP_N + j]);
          end
          if ($signed(win_q[g*aasp_pkg::GROUP_N + j]) < grp_lo_d[g]) begin
            grp_lo_d[g] = $signed(win_q[g*aasp_pkg::GROUP_N + j]);
          end
        end
      end
    end
  end

  // mean magnitude = floor(|sum| / WINDOW_LEN) by reciprocal multiply, exact for this range
  assign sum_abs = sum_q[SUM_W-1] ? (~sum_q + {{(SUM_W-1){1'b0}}, 1'b1}) : sum_q;
  assign prod    = PROD_W'(sum_abs) * PROD_W'(MEAN_M);

  always_ff @(posedge clk_i) begin
    if (reduce_i) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_hi_q[g] <= grp_hi_d[g];
        grp_lo_q[g] <= grp_lo_d[g];
      end
      mean_mag_q <= prod[MEAN_K +: SB];
      mean_neg_q <= sum_q[SUM_W-1];
    end
  end

  always_comb begin
    hi = grp_hi_q[0];
    lo = grp_lo_q[0];
    for (int g = 1; g < NGRP; g++) begin
      if (grp_hi_q[g] > hi) hi = grp_hi_q[g];
      if (grp_lo_q[g] < lo) lo = grp_lo_q[g];
    end
  end

  assign span_full = {hi[SB-1], hi} - {lo[SB-1], lo};

  assign res_o.span     = span_full[SB-1:0];
  assign res_o.mean_mag = mean_mag_q;
  // a mean truncated to zero is not negative
  assign res_o.mean_neg = mean_neg_q && (|mean_mag_q);
  assign res_o.newest   = win_q[WINDOW_LEN-1];

endmodule

>>> hdl/aasp_detect.sv
// merge of the three lanes: activity class, step detectors, walk/run latch and posture
module aasp_detect #(
  parameter int STEPS_TO_LATCH = aasp_pkg::STEPS_TO_LATCH_DEF,
  parameter int IDLE_SECONDS   = aasp_pkg::IDLE_SECONDS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        detect_i,
  input  aasp_pkg::cfg_t              cfg_i,
  input  logic [aasp_pkg::TICK_W-1:0] tick_i,
  input  logic [aasp_pkg::TICK_W-1:0] sec_i,
  input  aasp_pkg::lane_res_t         res_x_i,
  input  aasp_pkg::lane_res_t         res_y_i,
  input  aasp_pkg::lane_res_t         res_z_i,
  output aasp_pkg::stat_t             stat_o
);

  localparam int SB = aasp_pkg::SAMPLE_BITS;
  localparam int TW = aasp_pkg::TICK_W;
  localparam logic [aasp_pkg::COUNT_W-1:0] LATCH_N = aasp_pkg::COUNT_W'(STEPS_TO_LATCH);
  localparam logic [TW-1:0] IDLE_N = TW'(IDLE_SECONDS);

  logic [aasp_pkg::CODE_W-1:0]  posture_q, posture_d;
  logic                         high_q, high_d, low_q, low_d;
  logic                         walk_armed_q, walk_armed_d, run_armed_q, run_armed_d;
  logic                         walking_q, walking_d, running_q, running_d;
  logic [aasp_pkg::COUNT_W-1:0] walk_cnt_q, walk_cnt_d, run_cnt_q, run_cnt_d;
  logic [TW-1:0]                last_walk_q, last_walk_d, last_run_q, last_run_d;
  logic [TW-1:0]                last_motion_q, last_motion_d;
  logic                         idle_q, idle_d, walk_en_q, walk_en_d;

  logic        any_high, any_low;
  logic [SB:0] dev, adev;
  logic        dev_low, run_hit, walk_hit;
  logic        run_gap_ok, walk_gap_ok, idle_expire, step_seen;
  logic [TW-1:0] run_diff, walk_diff, sec_diff;

  assign any_high = (res_x_i.span > cfg_i.high_limit) || (res_y_i.span > cfg_i.high_limit)
                 || (res_z_i.span > cfg_i.high_limit);
  assign any_low  = (res_x_i.span > cfg_i.low_limit) || (res_y_i.span > cfg_i.low_limit)
                 || (res_z_i.span > cfg_i.low_limit);

  assign dev      = {res_x_i.newest[SB-1], res_x_i.newest} - {cfg_i.rest[SB-1], cfg_i.rest};
  assign adev     = dev[SB] ? (~dev + {{SB{1'b0}}, 1'b1}) : dev;
  assign dev_low  = $signed(dev) <= $signed({cfg_i.rearm[SB-1], cfg_i.rearm});
  assign run_hit  = adev > {1'b0, cfg_i.run_dev};
  assign walk_hit = adev > {1'b0, cfg_i.walk_dev};

  // tick differences wrap modulo 2^32
  assign run_diff    = tick_i - last_run_q;
  assign walk_diff   = tick_i - last_walk_q;
  assign sec_diff    = sec_i - last_motion_q;
  assign run_gap_ok  = run_diff > TW'(cfg_i.run_gap);
  assign walk_gap_ok = walk_diff > TW'(cfg_i.walk_gap);
  assign idle_expire = sec_diff > IDLE_N;

  always_comb begin
    posture_d     = posture_q;
    high_d        = high_q;
    low_d         = low_q;
    walk_armed_d  = walk_armed_q;
    run_armed_d   = run_armed_q;
    walking_d     = walking_q;
    running_d     = running_q;
    walk_cnt_d    = walk_cnt_q;
    run_cnt_d     = run_cnt_q;
    last_walk_d   = last_walk_q;
    last_run_d    = last_run_q;
    last_motion_d = last_motion_q;
    idle_d        = idle_q;
    walk_en_d     = walk_en_q;
    step_seen     = 1'b0;
    if (detect_i) begin
      // activity class, frozen while walking or running
      if (!running_q && !walking_q) begin
        if (any_high) begin
          low_d     = 1'b0;
          high_d    = 1'b1;
          posture_d = aasp_pkg::POS_HIGH;
        end else if (any_low) begin
          if (!high_q) begin
            low_d     = 1'b1;
            high_d    = 1'b0;
            posture_d = aasp_pkg::POS_LOW;
          end
        end else begin
          low_d  = 1'b0;
          high_d = 1'b0;
        end
      end

      // running step
      if (run_hit && !run_armed_q) begin
        if (run_gap_ok) begin
          if (run_cnt_q != '1) run_cnt_d = run_cnt_q + 1'b1;
          idle_d        = 1'b0;
          last_motion_d = sec_i;
          walk_en_d     = 1'b0;
          step_seen     = 1'b1;
        end
        run_armed_d = 1'b1;
        last_run_d  = tick_i;
        if (walk_armed_q) begin
          walk_armed_d = 1'b0;
          walk_cnt_d   = '0;
        end
      end else if (dev_low) begin
        run_armed_d = 1'b0;
      end

      // walking step, sees the run detector's updates
      if (walk_en_d) begin
        if (walk_hit && !walk_armed_d) begin
          if (walk_gap_ok) begin
            if (walk_cnt_d != '1) walk_cnt_d = walk_cnt_d + 1'b1;
            idle_d        = 1'b0;
            last_motion_d = sec_i;
            step_seen     = 1'b1;
          end
          walk_armed_d = 1'b1;
          last_walk_d  = tick_i;
        end else if (dev_low) begin
          walk_armed_d = 1'b0;
        end
      end

      if (walk_cnt_d >= LATCH_N && !walking_d) begin
        walking_d = 1'b1;
        posture_d = aasp_pkg::POS_WALK;
        if (running_d) begin
          running_d = 1'b0;
          run_cnt_d = '0;
        end
      end else if (walk_cnt_d < LATCH_N && walking_d) begin
        walking_d = 1'b0;
      end else if (run_cnt_d >= LATCH_N && !running_d) begin
        running_d = 1'b1;
        posture_d = aasp_pkg::POS_RUN;
        if (walking_d) begin
          walking_d  = 1'b0;
          walk_cnt_d = '0;
        end
      end else if (run_cnt_d < LATCH_N && running_d) begin
        running_d = 1'b0;
      end

      // a step this pass moves the motion mark to now, so no timeout then
      if (idle_expire && !step_seen && !idle_d) begin
        walking_d  = 1'b0;
        walk_cnt_d = '0;
        running_d  = 1'b0;
        run_cnt_d  = '0;
        idle_d     = 1'b1;
        walk_en_d  = 1'b1;
      end

      // still: posture from the axis with the strictly largest mean magnitude
      if (!high_d && !low_d && !running_d && !walking_d) begin
        if (res_z_i.mean_mag > res_x_i.mean_mag && res_z_i.mean_mag > res_y_i.mean_mag) begin
          posture_d = res_z_i.mean_neg ? aasp_pkg::POS_FACE_DOWN : aasp_pkg::POS_FACE_UP;
        end else if (res_y_i.mean_mag > res_z_i.mean_mag
                     && res_y_i.mean_mag > res_x_i.mean_mag) begin
          posture_d = res_y_i.mean_neg ? aasp_pkg::POS_LEFT : aasp_pkg::POS_RIGHT;
        end else if (res_x_i.mean_mag > res_z_i.mean_mag
                     && res_x_i.mean_mag > res_y_i.mean_mag) begin
          posture_d = res_x_i.mean_neg ? aasp_pkg::POS_HEAD_DOWN : aasp_pkg::POS_HEAD_UP;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      posture_q     <= aasp_pkg::POS_HEAD_UP;
      high_q        <= 1'b0;
      low_q         <= 1'b0;
      walk_armed_q  <= 1'b0;
      run_armed_q   <= 1'b0;
      walking_q     <= 1'b0;
      running_q     <= 1'b0;
      walk_cnt_q    <= '0;
      run_cnt_q     <= '0;
      last_walk_q   <= '0;
      last_run_q    <= '0;
      last_motion_q <= '0;
      idle_q        <= 1'b1;
      walk_en_q     <= 1'b1;
    end else begin
      posture_q     <= posture_d;
      high_q        <= high_d;
      low_q         <= low_d;
      walk_armed_q  <= walk_armed_d;
      run_armed_q   <= run_armed_d;
      walking_q     <= walking_d;
      running_q     <= running_d;
      walk_cnt_q    <= walk_cnt_d;
      run_cnt_q     <= run_cnt_d;
      last_walk_q   <= last_walk_d;
      last_run_q    <= last_run_d;
      last_motion_q <= last_motion_d;
      idle_q        <= idle_d;
      walk_en_q     <= walk_en_d;
    end
  end

  assign stat_o.posture    = posture_q;
  assign stat_o.walking    = walking_q;
  assign stat_o.running    = running_q;
  assign stat_o.walk_steps = walk_cnt_q;
  assign stat_o.run_steps  = run_cnt_q;

`ifndef ASSERT_OFF
  walk_run_exclusive_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(walking_q && running_q))
    else $error("walking and running latched together");

  walking_count_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    walking_q |-> (walk_cnt_q >= LATCH_N))
    else $error("walking latched below step threshold");

  running_count_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> (run_cnt_q >= LATCH_N))
    else $error("running latched below step threshold");

  idle_walk_en_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    idle_q |-> walk_en_q)
    else $error("idle with walk detector disabled");
`endif

endmodule
